/* hw/rtl/rvdec_pkg.sv */
// Types and encodings shared by the RV32I decoder and its users.
package rvdec_pkg;

   // Request: one instruction word and the address it was fetched from
   typedef struct packed {
      logic [31:0] insn_word;
      logic [31:0] insn_addr;
   } req_type;

   // Decoded result
   typedef struct packed {
      logic               illegal;
      logic [5:0]         op_index;
      logic [4:0]         dest_reg;
      logic [4:0]         src1_reg;
      logic [4:0]         src2_reg;
      logic signed [31:0] immediate;
      logic [31:0]        target;
   } rsp_type;

   // Major opcodes
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_ALUI   = 7'h13;
   localparam logic [6:0] OPC_ALUR   = 7'h33;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // Mnemonic numbers
   localparam logic [5:0] OP_LUI    = 6'd0;
   localparam logic [5:0] OP_AUIPC  = 6'd1;
   localparam logic [5:0] OP_JAL    = 6'd2;
   localparam logic [5:0] OP_JALR   = 6'd3;
   localparam logic [5:0] OP_BEQ    = 6'd4;
   localparam logic [5:0] OP_BNE    = 6'd5;
   localparam logic [5:0] OP_BLT    = 6'd6;
   localparam logic [5:0] OP_BGE    = 6'd7;
   localparam logic [5:0] OP_BLTU   = 6'd8;
   localparam logic [5:0] OP_BGEU   = 6'd9;
   localparam logic [5:0] OP_LB     = 6'd10;
   localparam logic [5:0] OP_LH     = 6'd11;
   localparam logic [5:0] OP_LW     = 6'd12;
   localparam logic [5:0] OP_LBU    = 6'd13;
   localparam logic [5:0] OP_LHU    = 6'd14;
   localparam logic [5:0] OP_SB     = 6'd15;
   localparam logic [5:0] OP_SH     = 6'd16;
   localparam logic [5:0] OP_SW     = 6'd17;
   localparam logic [5:0] OP_ADDI   = 6'd18;
   localparam logic [5:0] OP_SLTI   = 6'd19;
   localparam logic [5:0] OP_SLTIU  = 6'd20;
   localparam logic [5:0] OP_XORI   = 6'd21;
   localparam logic [5:0] OP_ORI    = 6'd22;
   localparam logic [5:0] OP_ANDI   = 6'd23;
   localparam logic [5:0] OP_SLLI   = 6'd24;
   localparam logic [5:0] OP_SRLI   = 6'd25;
   localparam logic [5:0] OP_SRAI   = 6'd26;
   localparam logic [5:0] OP_ADD    = 6'd27;
   localparam logic [5:0] OP_SUB    = 6'd28;
   localparam logic [5:0] OP_SLL    = 6'd29;
   localparam logic [5:0] OP_SLT    = 6'd30;
   localparam logic [5:0] OP_SLTU   = 6'd31;
   localparam logic [5:0] OP_XOR    = 6'd32;
   localparam logic [5:0] OP_SRL    = 6'd33;
   localparam logic [5:0] OP_SRA    = 6'd34;
   localparam logic [5:0] OP_OR     = 6'd35;
   localparam logic [5:0] OP_AND    = 6'd36;
   localparam logic [5:0] OP_ECALL  = 6'd37;
   localparam logic [5:0] OP_EBREAK = 6'd38;
   localparam logic [5:0] OP_CSRRW  = 6'd39;
   localparam logic [5:0] OP_CSRRS  = 6'd40;
   localparam logic [5:0] OP_CSRRC  = 6'd41;
   localparam logic [5:0] OP_CSRRWI = 6'd42;
   localparam logic [5:0] OP_CSRRSI = 6'd43;
   localparam logic [5:0] OP_CSRRCI = 6'd44;

endpackage

/* hw/rtl/rv32i_instruction_decoder.sv */
// RV32I instruction decoder: three-stage pipeline from word to decoded fields.
//
// Usage notes
// - Request channel: present req_data (instruction word and its address) with
//   start high; the request is taken at the clock edge where start is high and
//   busy is low. A new request may be taken on every cycle.
// - busy is high only while reset is held; the pipeline never backs up.
// - Result channel: rsp_valid strobes for one cycle with rsp_data. There is no
//   back-pressure: the receiver must take the result in that cycle.
// - A request goes through the stage 1, 2 and 3 registers to the result.
//   Throughput: one request per cycle, steady state, while reset is low.
// - Stage 1 registers the request, stage 2 classifies the word and builds the
//   immediate, stage 3 adds the immediate to the address for jal and branches.
//   The 32-bit target adder sets the depth of the last stage.
// - Illegal words give illegal = 1 with op_index, immediate and target zero;
//   register fields are always the raw slices.
// - Reset (synchronous, active high) drops every request in flight; payload
//   registers are not cleared.
module rv32i_instruction_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rvdec_pkg::req_type req_data,
   output logic              rsp_valid,
   output rvdec_pkg::rsp_type rsp_data
);

   // ---------------------------------------------------------------- stage 1
   logic        v1_ff,    v1_in;
   logic [31:0] word1_ff;
   logic [31:0] addr1_ff;

   assign busy  = reset;
   assign v1_in = start && !busy;

   // ---------------------------------------------------------------- stage 2
   // Field slices of the registered word
   logic [6:0]  opc;
   logic [2:0]  f3;
   logic [6:0]  f7;
   logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u, imm_sh, imm_csr;

   // Decode results
   logic        legal;
   logic [5:0]  op;
   logic [31:0] imm;
   logic        has_tgt;

   logic        v2_ff;
   logic        bad2_ff,  bad2_in;
   logic [5:0]  op2_ff,   op2_in;
   logic [31:0] imm2_ff,  imm2_in;
   logic        tgt2_ff,  tgt2_in;
   logic [31:0] addr2_ff;
   logic [14:0] regs2_ff;   // rd, rs1, rs2

   assign opc = word1_ff[6:0];
   assign f3  = word1_ff[14:12];
   assign f7  = word1_ff[31:25];

   assign imm_i   = {{20{word1_ff[31]}}, word1_ff[31:20]};
   assign imm_s   = {{20{word1_ff[31]}}, word1_ff[31:25], word1_ff[11:7]};
   assign imm_b   = {{19{word1_ff[31]}}, word1_ff[31], word1_ff[7],
                     word1_ff[30:25], word1_ff[11:8], 1'b0};
   assign imm_j   = {{11{word1_ff[31]}}, word1_ff[31], word1_ff[19:12],
                     word1_ff[20], word1_ff[30:21], 1'b0};
   assign imm_u   = {word1_ff[31:12], 12'h000};
   assign imm_sh  = {27'd0, word1_ff[24:20]};
   assign imm_csr = {20'd0, word1_ff[31:20]};

   always_comb begin
      legal   = 1'b0;
      op      = rvdec_pkg::OP_LUI;
      imm     = '0;
      has_tgt = 1'b0;
      unique case (opc)
         rvdec_pkg::OPC_LUI: begin
            legal = 1'b1; op = rvdec_pkg::OP_LUI; imm = imm_u;
         end
         rvdec_pkg::OPC_AUIPC: begin
            legal = 1'b1; op = rvdec_pkg::OP_AUIPC; imm = imm_u;
         end
         rvdec_pkg::OPC_JAL: begin
            legal = 1'b1; op = rvdec_pkg::OP_JAL; imm = imm_j; has_tgt = 1'b1;
         end
         rvdec_pkg::OPC_JALR: begin
            legal = (f3 == 3'd0); op = rvdec_pkg::OP_JALR; imm = imm_i;
         end
         rvdec_pkg::OPC_BRANCH: begin
            imm     = imm_b;
            has_tgt = 1'b1;
            legal   = 1'b1;
            unique case (f3)
               3'd0:    op = rvdec_pkg::OP_BEQ;
               3'd1:    op = rvdec_pkg::OP_BNE;
               3'd4:    op = rvdec_pkg::OP_BLT;
               3'd5:    op = rvdec_pkg::OP_BGE;
               3'd6:    op = rvdec_pkg::OP_BLTU;
               3'd7:    op = rvdec_pkg::OP_BGEU;
               default: legal = 1'b0;
            endcase
         end
         rvdec_pkg::OPC_LOAD: begin
            imm   = imm_i;
            legal = 1'b1;
            unique case (f3)
               3'd0:    op = rvdec_pkg::OP_LB;
               3'd1:    op = rvdec_pkg::OP_LH;
               3'd2:    op = rvdec_pkg::OP_LW;
               3'd4:    op = rvdec_pkg::OP_LBU;
               3'd5:    op = rvdec_pkg::OP_LHU;
               default: legal = 1'b0;
            endcase
         end
         rvdec_pkg::OPC_STORE: begin
            imm   = imm_s;
            legal = 1'b1;
            unique case (f3)
               3'd0:    op = rvdec_pkg::OP_SB;
               3'd1:    op = rvdec_pkg::OP_SH;
               3'd2:    op = rvdec_pkg::OP_SW;
               default: legal = 1'b0;
            endcase
         end
         rvdec_pkg::OPC_ALUI: begin
            legal = 1'b1;
            imm   = imm_i;
            unique case (f3)
               3'd0: op = rvdec_pkg::OP_ADDI;
               3'd1: begin
                  op    = rvdec_pkg::OP_SLLI;
                  imm   = imm_sh;
                  legal = (f7 == rvdec_pkg::F7_BASE);
               end
               3'd2: op = rvdec_pkg::OP_SLTI;
               3'd3: op = rvdec_pkg::OP_SLTIU;
               3'd4: op = rvdec_pkg::OP_XORI;
               3'd5: begin
                  op    = (f7 == rvdec_pkg::F7_ALT) ? rvdec_pkg::OP_SRAI
                                                    : rvdec_pkg::OP_SRLI;
                  imm   = imm_sh;
                  legal = (f7 == rvdec_pkg::F7_BASE) || (f7 == rvdec_pkg::F7_ALT);
               end
               3'd6: op = rvdec_pkg::OP_ORI;
               3'd7: op = rvdec_pkg::OP_ANDI;
               default: legal = 1'b0;
            endcase
         end
         rvdec_pkg::OPC_ALUR: begin
            if (f7 == rvdec_pkg::F7_BASE) begin
               legal = 1'b1;
               unique case (f3)
                  3'd0:    op = rvdec_pkg::OP_ADD;
                  3'd1:    op = rvdec_pkg::OP_SLL;
                  3'd2:    op = rvdec_pkg::OP_SLT;
                  3'd3:    op = rvdec_pkg::OP_SLTU;
                  3'd4:    op = rvdec_pkg::OP_XOR;
                  3'd5:    op = rvdec_pkg::OP_SRL;
                  3'd6:    op = rvdec_pkg::OP_OR;
                  3'd7:    op = rvdec_pkg::OP_AND;
                  default: legal = 1'b0;
               endcase
            end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd0) begin
               legal = 1'b1; op = rvdec_pkg::OP_SUB;
            end else if (f7 == rvdec_pkg::F7_ALT && f3 == 3'd5) begin
               legal = 1'b1; op = rvdec_pkg::OP_SRA;
            end
         end
         rvdec_pkg::OPC_SYSTEM: begin
            imm   = imm_csr;
            legal = 1'b1;
            unique case (f3)
               3'd0: begin
                  imm = '0;
                  if (word1_ff == rvdec_pkg::WORD_ECALL) begin
                     op = rvdec_pkg::OP_ECALL;
                  end else if (word1_ff == rvdec_pkg::WORD_EBREAK) begin
                     op = rvdec_pkg::OP_EBREAK;
                  end else begin
                     legal = 1'b0;
                  end
               end
               3'd1:    op = rvdec_pkg::OP_CSRRW;
               3'd2:    op = rvdec_pkg::OP_CSRRS;
               3'd3:    op = rvdec_pkg::OP_CSRRC;
               3'd5:    op = rvdec_pkg::OP_CSRRWI;
               3'd6:    op = rvdec_pkg::OP_CSRRSI;
               3'd7:    op = rvdec_pkg::OP_CSRRCI;
               default: legal = 1'b0;
            endcase
         end
         default: legal = 1'b0;   // fence and unknown opcodes
      endcase
   end

   // Illegal words carry zero op, immediate and no target
   assign bad2_in = !legal;
   assign op2_in  = legal ? op  : rvdec_pkg::OP_LUI;
   assign imm2_in = legal ? imm : 32'd0;
   assign tgt2_in = legal && has_tgt;

   // ---------------------------------------------------------------- stage 3
   logic               v3_ff;
   rvdec_pkg::rsp_type rsp_ff, rsp_in;

   always_comb begin
      rsp_in.illegal   = bad2_ff;
      rsp_in.op_index  = op2_ff;
      rsp_in.dest_reg  = regs2_ff[14:10];
      rsp_in.src1_reg  = regs2_ff[9:5];
      rsp_in.src2_reg  = regs2_ff[4:0];
      rsp_in.immediate = imm2_ff;
      rsp_in.target    = tgt2_ff ? (addr2_ff + imm2_ff) : 32'd0;
   end

   // ------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_in) begin
         word1_ff <= req_data.insn_word;
         addr1_ff <= req_data.insn_addr;
      end
      if (v1_ff) begin
         bad2_ff  <= bad2_in;
         op2_ff   <= op2_in;
         imm2_ff  <= imm2_in;
         tgt2_ff  <= tgt2_in;
         addr2_ff <= addr1_ff;
         regs2_ff <= {word1_ff[11:7], word1_ff[19:15], word1_ff[24:20]};
      end
      if (v2_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------ assertions
   // Every accepted request comes out as a result
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##3 rsp_valid)
      else $error("accepted request did not produce a result");

   // No result without an earlier accepted request
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result without request");

   // The rd and rs2 fields stay aligned with their word through the pipe
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.dest_reg == $past(req_data.insn_word[11:7], 3)
                  && rsp_data.src2_reg == $past(req_data.insn_word[24:20], 3)))
      else $error("register fields misaligned");

   // Illegal words have op_index, immediate and target zeroed
   a_illegal_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.illegal) |->
         (rsp_data.op_index == rvdec_pkg::OP_LUI && rsp_data.immediate == 0
          && rsp_data.target == 32'd0))
      else $error("illegal result not zeroed");

   // Only jal and branches carry a target
   a_target_ops: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.target != 32'd0) |->
         (rsp_data.op_index == rvdec_pkg::OP_JAL
          || rsp_data.op_index == rvdec_pkg::OP_BEQ
          || rsp_data.op_index == rvdec_pkg::OP_BNE
          || rsp_data.op_index == rvdec_pkg::OP_BLT
          || rsp_data.op_index == rvdec_pkg::OP_BGE
          || rsp_data.op_index == rvdec_pkg::OP_BLTU
          || rsp_data.op_index == rvdec_pkg::OP_BGEU))
      else $error("target on a non-branch");

endmodule
